// ===== src/assert_macros.svh =====
// Assertion helpers shared by the RTL.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTH
`define ASSERT_IMPL(label, clk, rstn, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
        else $error("assertion failed");
`define ASSERT_NEXT(label, clk, rstn, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
        else $error("assertion failed");
`else
`define ASSERT_IMPL(label, clk, rstn, ante, cons)
`define ASSERT_NEXT(label, clk, rstn, ante, cons)
`endif
`endif

// ===== src/rau_pkg.sv =====
package rau_pkg;

    localparam int OPERAND_WIDTH_DEF = 32;

    typedef enum logic [2:0] {
        OP_NORM = 3'd0,
        OP_ADD  = 3'd1,
        OP_SUB  = 3'd2,
        OP_MUL  = 3'd3,
        OP_DIV  = 3'd4,
        OP_CMP  = 3'd5
    } rau_op_t;

    typedef enum logic [1:0] {
        ST_OK       = 2'd0,
        ST_ZERO_DEN = 2'd1,
        ST_DIV_ZERO = 2'd2,
        ST_OVERFLOW = 2'd3
    } rau_status_t;

    typedef enum logic [1:0] {
        CMP_LESS  = 2'd0,
        CMP_EQUAL = 2'd1,
        CMP_GREATER = 2'd2
    } rau_cmp_t;

    typedef struct packed {
        logic [2:0]         req_type;
        logic signed [31:0] a_num;
        logic signed [31:0] a_den;
        logic signed [31:0] b_num;
        logic signed [31:0] b_den;
    } rau_req_t;

    typedef struct packed {
        logic signed [63:0] res_num;
        logic [62:0]        res_den;
        logic [1:0]         cmp_result;
        logic [1:0]         status;
    } rau_res_t;

    // Binary gcd sequencer states.
    typedef enum logic [1:0] {G_IDLE, G_COMMON, G_RUN} rau_gcd_state_t;

    typedef enum logic [3:0] {
        S_IDLE,
        S_MUL0,
        S_MUL1,
        S_MUL2,
        S_COMBINE,
        S_GCD_START,
        S_GCD_WAIT,
        S_DIVN_START,
        S_DIVN_WAIT,
        S_DIVD_START,
        S_DIVD_WAIT,
        S_FINISH,
        S_OUT
    } rau_state_t;

endpackage

// ===== src/rau_mul.sv =====
module rau_mul
    import rau_pkg::*;
#(
    parameter int W = OPERAND_WIDTH_DEF
) (
    input  logic           aclk,
    input  logic           aresetn,
    input  logic           start,
    input  logic [W-1:0]   op_a,
    input  logic [W-1:0]   op_b,
    output logic [2*W-1:0] product,
    output logic           done
);
    logic [2*W-1:0] prod_reg;
    logic           done_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            done_reg <= 1'b0;
        end else begin
            done_reg <= start;
        end
        if (start) begin
            prod_reg <= op_a * op_b;
        end
    end

    assign product = prod_reg;
    assign done    = done_reg;
endmodule

// ===== src/rau_gcd.sv =====
`include "assert_macros.svh"
module rau_gcd
    import rau_pkg::*;
(
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        start,
    input  logic [63:0] x_in,
    input  logic [63:0] y_in,
    output logic [63:0] gcd,
    output logic        done
);
    // Binary gcd: strip common twos, then subtract-and-shift one step per cycle.
    rau_gcd_state_t st_reg, st_next;
    logic [63:0] x_reg, x_next, y_reg, y_next;
    logic [6:0]  sh_reg, sh_next;
    logic        done_reg, done_next;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            st_reg   <= G_IDLE;
            done_reg <= 1'b0;
        end else begin
            st_reg   <= st_next;
            done_reg <= done_next;
        end
        x_reg  <= x_next;
        y_reg  <= y_next;
        sh_reg <= sh_next;
    end

    always_comb begin
        st_next   = st_reg;
        x_next    = x_reg;
        y_next    = y_reg;
        sh_next   = sh_reg;
        done_next = 1'b0;
        case (st_reg)
            G_IDLE: begin
                if (start) begin
                    x_next  = x_in;
                    y_next  = y_in;
                    sh_next = '0;
                    st_next = G_COMMON;
                end
            end
            G_COMMON: begin
                if (((x_reg | y_reg) & 64'd1) == 64'd0) begin
                    x_next  = x_reg >> 1;
                    y_next  = y_reg >> 1;
                    sh_next = sh_reg + 7'd1;
                end else begin
                    st_next = G_RUN;
                end
            end
            G_RUN: begin
                if (!x_reg[0]) begin
                    x_next = x_reg >> 1;
                end else if (y_reg == 64'd0) begin
                    st_next   = G_IDLE;
                    done_next = 1'b1;
                end else if (!y_reg[0]) begin
                    y_next = y_reg >> 1;
                end else if (x_reg > y_reg) begin
                    x_next = y_reg;
                    y_next = x_reg - y_reg;
                end else begin
                    y_next = y_reg - x_reg;
                end
            end
            default: st_next = G_IDLE;
        endcase
    end

    assign gcd  = x_reg << sh_reg[5:0];
    assign done = done_reg;

    `ASSERT_NEXT(a_gcd_done_idle, aclk, aresetn, done_reg, st_reg == G_IDLE || start)
    `ASSERT_IMPL(a_gcd_shift, aclk, aresetn, st_reg != G_IDLE, sh_reg < 7'd64)
    `ASSERT_IMPL(a_gcd_odd, aclk, aresetn, st_reg == G_RUN && y_reg != 64'd0, x_reg != 64'd0)
endmodule

// ===== src/rau_div.sv =====
module rau_div
    import rau_pkg::*;
(
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        start,
    input  logic [63:0] dividend,
    input  logic [63:0] divisor,
    output logic [63:0] quotient,
    output logic        done
);
    // Restoring division, one quotient bit per cycle.
    logic [63:0] q_reg, q_next, r_reg, r_next, d_reg, d_next;
    logic [6:0]  cnt_reg, cnt_next;
    logic        busy_reg, busy_next, done_reg, done_next;
    logic [64:0] trial;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
        end else begin
            busy_reg <= busy_next;
            done_reg <= done_next;
        end
        q_reg   <= q_next;
        r_reg   <= r_next;
        d_reg   <= d_next;
        cnt_reg <= cnt_next;
    end

    always_comb begin
        q_next    = q_reg;
        r_next    = r_reg;
        d_next    = d_reg;
        cnt_next  = cnt_reg;
        busy_next = busy_reg;
        done_next = 1'b0;
        trial     = {r_reg, q_reg[63]};
        if (!busy_reg) begin
            if (start) begin
                q_next    = dividend;
                r_next    = '0;
                d_next    = divisor;
                cnt_next  = '0;
                busy_next = 1'b1;
            end
        end else begin
            if (trial >= {1'b0, d_reg}) begin
                r_next = 64'(trial - {1'b0, d_reg});
                q_next = {q_reg[62:0], 1'b1};
            end else begin
                r_next = trial[63:0];
                q_next = {q_reg[62:0], 1'b0};
            end
            cnt_next = cnt_reg + 7'd1;
            if (cnt_reg == 7'd63) begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    assign quotient = q_reg;
    assign done     = done_reg;
endmodule

// ===== src/rational_arithmetic_unit.sv =====
// Rational arithmetic unit: one request in, one reduced fraction, compare result or status out.
// Sequence: cross and denominator products (none for normalize), binary gcd, then two
// restoring divisions by the gcd; errors, compares and zero results skip the gcd and
// the divisions.
// Throughput: one item at a time; s_ready is low from acceptance until after the m_ transfer.
// Reset: aresetn synchronous active low; returns the sequencer to idle, no result pending.
`include "assert_macros.svh"
module rational_arithmetic_unit
    import rau_pkg::*;
#(
    parameter int OPERAND_WIDTH = OPERAND_WIDTH_DEF
) (
    input  logic     aclk,
    input  logic     aresetn,
    input  logic     s_valid,
    output logic     s_ready,
    input  rau_req_t s_data,
    output logic     m_valid,
    input  logic     m_ready,
    output rau_res_t m_data
);
    localparam int W = OPERAND_WIDTH;

    rau_state_t st_reg, st_next;

    // Operand magnitudes and signs, captured at transfer.
    logic [W-1:0] an_reg, ad_reg, bn_reg, bd_reg;
    logic         an_neg_reg, bn_neg_reg;
    logic [2:0]   op_reg;
    logic [W-1:0] an_m, ad_m, bn_m, bd_m;
    logic         an_s, ad_s, bn_s, bd_s;

    // Working fraction.
    logic [63:0] l_reg, l_next, r_reg, r_next, den_reg, den_next;
    logic [63:0] g_reg, g_next, n_reg, n_next;
    logic        neg_reg, neg_next;
    rau_res_t    res_reg, res_next;

    // Shared multiplier.
    logic         mul_start;
    logic [W-1:0] mul_a, mul_b;
    logic [2*W-1:0] mul_p;
    logic         mul_done;

    logic         gcd_start, gcd_done;
    logic [63:0]  gcd_val;
    logic         div_start, div_done;
    logic [63:0]  div_a, div_q;

    function automatic logic [W-1:0] mag_of(input logic [31:0] raw);
        logic [W-1:0] v;
        v = raw[W-1:0];
        return v[W-1] ? W'(-v) : v;
    endfunction

    assign an_m = mag_of(s_data.a_num);
    assign ad_m = mag_of(s_data.a_den);
    assign bn_m = mag_of(s_data.b_num);
    assign bd_m = mag_of(s_data.b_den);
    assign an_s = s_data.a_num[W-1];
    assign ad_s = s_data.a_den[W-1];
    assign bn_s = s_data.b_num[W-1];
    assign bd_s = s_data.b_den[W-1];

    rau_mul #(.W(W)) u_mul (
        .aclk(aclk), .aresetn(aresetn), .start(mul_start),
        .op_a(mul_a), .op_b(mul_b), .product(mul_p), .done(mul_done)
    );

    rau_gcd u_gcd (
        .aclk(aclk), .aresetn(aresetn), .start(gcd_start),
        .x_in(l_reg), .y_in(den_reg), .gcd(gcd_val), .done(gcd_done)
    );

    rau_div u_div (
        .aclk(aclk), .aresetn(aresetn), .start(div_start),
        .dividend(div_a), .divisor(g_reg), .quotient(div_q), .done(div_done)
    );

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            st_reg <= S_IDLE;
        end else begin
            st_reg <= st_next;
        end
        if (s_valid && s_ready) begin
            an_reg     <= an_m;
            ad_reg     <= ad_m;
            bn_reg     <= bn_m;
            bd_reg     <= bd_m;
            op_reg     <= s_data.req_type;
            // Fold each denominator's sign into its numerator.
            an_neg_reg <= (an_s != ad_s) && (an_m != '0);
            bn_neg_reg <= (bn_s != bd_s) && (bn_m != '0);
        end
        l_reg   <= l_next;
        r_reg   <= r_next;
        den_reg <= den_next;
        g_reg   <= g_next;
        n_reg   <= n_next;
        neg_reg <= neg_next;
        res_reg <= res_next;
    end

    // Multiplier operand select per step: step0 left cross term, step1 right, step2 den.
    always_comb begin
        mul_a = an_reg;
        mul_b = bd_reg;
        case (st_reg)
            S_MUL0: begin
                mul_a = an_reg;
                mul_b = (op_reg == OP_MUL) ? bn_reg : bd_reg;
            end
            S_MUL1: begin
                mul_a = bn_reg;
                mul_b = ad_reg;
            end
            S_MUL2: begin
                mul_a = ad_reg;
                mul_b = (op_reg == OP_DIV) ? bn_reg : bd_reg;
            end
            default: begin
                mul_a = an_reg;
                mul_b = bd_reg;
            end
        endcase
    end

    assign div_a = (st_reg == S_DIVN_START) ? l_reg : den_reg;

    always_comb begin
        logic        bneg;
        logic [63:0] prod;
        st_next   = st_reg;
        l_next    = l_reg;
        r_next    = r_reg;
        den_next  = den_reg;
        g_next    = g_reg;
        n_next    = n_reg;
        neg_next  = neg_reg;
        res_next  = res_reg;
        mul_start = 1'b0;
        gcd_start = 1'b0;
        div_start = 1'b0;
        prod      = 64'(mul_p);
        bneg      = (op_reg == OP_SUB) ? !bn_neg_reg : bn_neg_reg;
        case (st_reg)
            S_IDLE: begin
                if (s_valid) begin
                    res_next.res_num    = '0;
                    res_next.res_den    = 63'd1;
                    res_next.cmp_result = CMP_LESS;
                    res_next.status     = ST_OK;
                    st_next = S_MUL0;
                end
            end
            S_MUL0: begin
                if (op_reg > OP_CMP) begin
                    st_next = S_OUT;
                end else if (ad_reg == '0 || (op_reg != OP_NORM && bd_reg == '0)) begin
                    res_next.status = ST_ZERO_DEN;
                    st_next = S_OUT;
                end else if (op_reg == OP_DIV && bn_reg == '0) begin
                    res_next.status = ST_DIV_ZERO;
                    st_next = S_OUT;
                end else if (op_reg == OP_NORM) begin
                    l_next   = 64'(an_reg);
                    den_next = 64'(ad_reg);
                    neg_next = an_neg_reg;
                    st_next  = S_COMBINE;
                end else begin
                    mul_start = 1'b1;
                    st_next   = S_MUL1;
                end
            end
            S_MUL1: begin
                // Left term ready next; capture as it arrives.
                if (mul_done) begin
                    l_next    = prod;
                    mul_start = 1'b1;
                    st_next   = S_MUL2;
                end
            end
            S_MUL2: begin
                if (mul_done) begin
                    r_next    = prod;
                    mul_start = 1'b1;
                    st_next   = S_COMBINE;
                end
            end
            S_COMBINE: begin
                if (op_reg != OP_NORM && !mul_done) begin
                    st_next = S_COMBINE;
                end else begin
                    if (op_reg != OP_NORM) begin
                        den_next = prod;
                    end
                    case (op_reg)
                        OP_ADD, OP_SUB: begin
                            if (an_neg_reg == bneg) begin
                                l_next   = l_reg + r_reg;
                                neg_next = an_neg_reg;
                            end else if (l_reg >= r_reg) begin
                                l_next   = l_reg - r_reg;
                                neg_next = an_neg_reg;
                            end else begin
                                l_next   = r_reg - l_reg;
                                neg_next = bneg;
                            end
                        end
                        OP_MUL: begin
                            // Hold the a_num * b_num product from the first step.
                            neg_next = an_neg_reg != bn_neg_reg;
                        end
                        OP_DIV: begin
                            neg_next = an_neg_reg != bn_neg_reg;
                        end
                        OP_CMP: begin
                            if (an_neg_reg != bn_neg_reg) begin
                                res_next.cmp_result = an_neg_reg ? CMP_LESS : CMP_GREATER;
                            end else if (l_reg == r_reg) begin
                                res_next.cmp_result = CMP_EQUAL;
                            end else if (an_neg_reg) begin
                                res_next.cmp_result = (l_reg > r_reg) ? CMP_LESS : CMP_GREATER;
                            end else begin
                                res_next.cmp_result = (l_reg > r_reg) ? CMP_GREATER : CMP_LESS;
                            end
                        end
                        default: begin
                            neg_next = neg_reg;
                        end
                    endcase
                    st_next = (op_reg == OP_CMP) ? S_OUT : S_GCD_START;
                end
            end
            S_GCD_START: begin
                if (l_reg == 64'd0) begin
                    st_next = S_OUT;
                end else begin
                    gcd_start = 1'b1;
                    st_next   = S_GCD_WAIT;
                end
            end
            S_GCD_WAIT: begin
                if (gcd_done) begin
                    g_next  = gcd_val;
                    st_next = S_DIVN_START;
                end
            end
            S_DIVN_START: begin
                div_start = 1'b1;
                st_next   = S_DIVN_WAIT;
            end
            S_DIVN_WAIT: begin
                if (div_done) begin
                    n_next  = div_q;
                    st_next = S_DIVD_START;
                end
            end
            S_DIVD_START: begin
                div_start = 1'b1;
                st_next   = S_DIVD_WAIT;
            end
            S_DIVD_WAIT: begin
                if (div_done) begin
                    den_next = div_q;
                    st_next  = S_FINISH;
                end
            end
            S_FINISH: begin
                if ((neg_reg ? (n_reg > 64'h8000_0000_0000_0000)
                             : n_reg[63]) || den_reg[63]) begin
                    res_next.status = ST_OVERFLOW;
                end else begin
                    res_next.res_num = neg_reg ? -n_reg : n_reg;
                    res_next.res_den = den_reg[62:0];
                end
                st_next = S_OUT;
            end
            S_OUT: begin
                if (m_ready) begin
                    st_next = S_IDLE;
                end
            end
            default: st_next = S_IDLE;
        endcase
    end

    // The MUL0 step for add/sub/cmp uses a*d first; the mul case swaps in b_num.
    assign s_ready = (st_reg == S_IDLE);
    assign m_valid = (st_reg == S_OUT);
    assign m_data  = res_reg;

    `ASSERT_IMPL(a_one_side, aclk, aresetn, 1'b1, !(s_ready && m_valid))
    `ASSERT_NEXT(a_out_hold, aclk, aresetn, m_valid && !m_ready, m_valid)
    `ASSERT_IMPL(a_den_pos, aclk, aresetn, m_valid, m_data.res_den != 63'd0)
    `ASSERT_IMPL(a_err_frac, aclk, aresetn, m_valid && m_data.status != ST_OK,
        m_data.res_num == 64'sd0 && m_data.res_den == 63'd1)
endmodule

// ===== sim/rational_arithmetic_unit_tb.sv =====
`timescale 1ns / 1ps

module rational_arithmetic_unit_tb;
    import rau_pkg::*;

    // Split a 32-bit operand into sign and magnitude, widened to 64 bits.
    typedef struct {
        logic        neg;
        logic [63:0] mag;
    } sign_mag_t;

    typedef struct {
        rau_req_t req;
        logic     has_known;
        rau_res_t known;
    } stim_row_t;

    logic     aclk;
    logic     aresetn;
    logic     s_valid;
    logic     s_ready;
    rau_req_t s_data;
    logic     m_valid;
    logic     m_ready;
    rau_res_t m_data;

    rau_res_t   expected_results[$];
    int         error_count;
    int         sender_idle_pct;
    int         receiver_stall_pct;
    int         accept_count;
    stim_row_t  directed_rows[$];

    rational_arithmetic_unit dut (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .s_data  (s_data),
        .m_valid (m_valid),
        .m_ready (m_ready),
        .m_data  (m_data)
    );

    initial begin
        aclk = 1'b0;
        forever #5 aclk = ~aclk;
    end

    // Hard stop well beyond the slowest legal run.
    initial begin
        #200ms;
        $display("rational_arithmetic_unit verification failed");
        $finish;
    end

    function automatic sign_mag_t split_field(logic [31:0] raw);
        sign_mag_t r;
        r.neg = raw[31];
        r.mag = raw[31] ? {32'd0, (~raw) + 32'd1} : {32'd0, raw};
        if (raw[31] && r.mag == 64'd0) begin
            r.mag = 64'h8000_0000;
        end
        return r;
    endfunction

    function automatic sign_mag_t add_signed_mag(sign_mag_t x, sign_mag_t y);
        sign_mag_t r;
        if (x.neg == y.neg) begin
            r.neg = x.neg;
            r.mag = x.mag + y.mag;
        end else if (x.mag >= y.mag) begin
            r.neg = x.neg;
            r.mag = x.mag - y.mag;
        end else begin
            r.neg = y.neg;
            r.mag = y.mag - x.mag;
        end
        if (r.mag == 64'd0) begin
            r.neg = 1'b0;
        end
        return r;
    endfunction

    function automatic rau_cmp_t order_of(sign_mag_t x, sign_mag_t y);
        if (x.mag == 64'd0) x.neg = 1'b0;
        if (y.mag == 64'd0) y.neg = 1'b0;
        if (x.neg != y.neg) return x.neg ? CMP_LESS : CMP_GREATER;
        if (x.mag == y.mag) return CMP_EQUAL;
        if (x.neg) return (x.mag > y.mag) ? CMP_LESS : CMP_GREATER;
        return (x.mag > y.mag) ? CMP_GREATER : CMP_LESS;
    endfunction

    function automatic logic [63:0] binary_gcd(logic [63:0] x, logic [63:0] y);
        logic [63:0] t;
        int          shift;
        shift = 0;
        while (((x | y) & 64'd1) == 64'd0) begin
            x = x >> 1;
            y = y >> 1;
            shift++;
        end
        while (x[0] == 1'b0) x = x >> 1;
        while (y != 64'd0) begin
            while (y[0] == 1'b0) y = y >> 1;
            if (x > y) begin
                t = x;
                x = y;
                y = t;
            end
            y = y - x;
        end
        return x << shift;
    endfunction

    // Reduced fraction (or status / compare outcome) for one request.
    function automatic rau_res_t reduced_fraction(rau_req_t req);
        rau_res_t    res;
        sign_mag_t   an, ad, bn, bd, num, den, lhs, rhs;
        logic        have_frac;
        logic [63:0] g, n, d;
        logic        over;
        an = split_field(req.a_num);
        ad = split_field(req.a_den);
        bn = split_field(req.b_num);
        bd = split_field(req.b_den);
        res.res_num    = '0;
        res.res_den    = 63'd1;
        res.cmp_result = CMP_LESS;
        res.status     = ST_OK;
        an.neg = (an.neg != ad.neg) && an.mag != 0;
        bn.neg = (bn.neg != bd.neg) && bn.mag != 0;
        num.neg = 1'b0;
        num.mag = 64'd0;
        den.neg = 1'b0;
        den.mag = 64'd1;
        have_frac = 1'b1;
        if (req.req_type > OP_CMP) begin
            have_frac = 1'b0;
        end else if (ad.mag == 0 || (req.req_type != OP_NORM && bd.mag == 0)) begin
            res.status = ST_ZERO_DEN;
            have_frac  = 1'b0;
        end else if (req.req_type == OP_DIV && bn.mag == 0) begin
            res.status = ST_DIV_ZERO;
            have_frac  = 1'b0;
        end else begin
            case (req.req_type)
                OP_NORM: begin
                    num     = an;
                    den.mag = ad.mag;
                end
                OP_ADD, OP_SUB: begin
                    lhs.neg = an.neg;
                    lhs.mag = an.mag * bd.mag;
                    rhs.neg = (req.req_type == OP_SUB) ? !bn.neg : bn.neg;
                    rhs.mag = bn.mag * ad.mag;
                    num     = add_signed_mag(lhs, rhs);
                    den.mag = ad.mag * bd.mag;
                end
                OP_MUL: begin
                    num.neg = an.neg != bn.neg;
                    num.mag = an.mag * bn.mag;
                    den.mag = ad.mag * bd.mag;
                end
                OP_DIV: begin
                    num.neg = an.neg != bn.neg;
                    num.mag = an.mag * bd.mag;
                    den.mag = ad.mag * bn.mag;
                end
                default: begin
                    lhs.neg = an.neg;
                    lhs.mag = an.mag * bd.mag;
                    rhs.neg = bn.neg;
                    rhs.mag = bn.mag * ad.mag;
                    res.cmp_result = order_of(lhs, rhs);
                    have_frac = 1'b0;
                end
            endcase
        end
        if (have_frac && num.mag != 0) begin
            g = binary_gcd(num.mag, den.mag);
            n = num.mag / g;
            d = den.mag / g;
            over = num.neg ? (n > 64'h8000_0000_0000_0000) : (n > 64'h7FFF_FFFF_FFFF_FFFF);
            if (over || d > 64'h7FFF_FFFF_FFFF_FFFF) begin
                res.status = ST_OVERFLOW;
            end else begin
                res.res_num = num.neg ? (64'd0 - n) : n;
                res.res_den = d[62:0];
            end
        end
        return res;
    endfunction

    task automatic report_mismatch(string what, logic [63:0] got, logic [63:0] want);
        $display("MISMATCH %s: got %0h, expected %0h at %0t", what, got, want, $realtime);
        error_count++;
    endtask

    function automatic rau_req_t make_req(rau_op_t op, int an, int ad, int bn, int bd);
        rau_req_t r;
        r.req_type = op;
        r.a_num    = an;
        r.a_den    = ad;
        r.b_num    = bn;
        r.b_den    = bd;
        return r;
    endfunction

    function automatic rau_res_t make_res(longint num, longint den, rau_cmp_t c,
                                          rau_status_t st);
        rau_res_t r;
        r.res_num    = num;
        r.res_den    = den[62:0];
        r.cmp_result = c;
        r.status     = st;
        return r;
    endfunction

    task automatic add_row(rau_req_t req, logic known_ok, rau_res_t known);
        stim_row_t row;
        row.req       = req;
        row.has_known = known_ok;
        row.known     = known;
        directed_rows.push_back(row);
    endtask

    // Operand value biased toward edges, small values and full range.
    function automatic logic [31:0] pick_operand();
        case ($urandom_range(0, 9))
            0: return 32'h8000_0000;
            1: return 32'h7FFF_FFFF;
            2, 3: return $urandom_range(0, 12) - 6;
            4: return {$urandom_range(0, 1) ? 16'hFFFF : 16'h0, 16'($urandom)};
            default: return $urandom;
        endcase
    endfunction

    function automatic rau_req_t random_req();
        rau_req_t r;
        r.req_type = ($urandom_range(0, 19) == 0) ? 3'($urandom_range(6, 7))
                                                   : 3'($urandom_range(0, 5));
        r.a_num = pick_operand();
        r.a_den = pick_operand();
        r.b_num = pick_operand();
        r.b_den = pick_operand();
        // Keep zero denominators rare so most transfers reach the datapath.
        if (r.a_den == 0 && $urandom_range(0, 3) != 0) r.a_den = 1;
        if (r.b_den == 0 && $urandom_range(0, 3) != 0) r.b_den = -1;
        return r;
    endfunction

    // Offer one request; valid stays up after the transfer until the next call drives it.
    task automatic send_request(rau_req_t req);
        while ($urandom_range(0, 99) < sender_idle_pct) begin
            s_valid <= 1'b0;
            @(posedge aclk);
        end
        s_valid <= 1'b1;
        s_data  <= req;
        @(posedge aclk);
        while (!s_ready) @(posedge aclk);
    endtask

    // Push the expectation on the accepting edge: typed result for known directed rows, else predicted.
    always @(posedge aclk) begin
        if (aresetn && s_valid && s_ready) begin
            if (accept_count < directed_rows.size() && directed_rows[accept_count].has_known)
                expected_results.push_back(directed_rows[accept_count].known);
            else
                expected_results.push_back(reduced_fraction(s_data));
            accept_count++;
        end
    end

    // Receiver: stall randomly and check each result transfer.
    always @(posedge aclk) begin
        rau_res_t want;
        if (!aresetn) begin
            m_ready <= 1'b0;
        end else begin
            if (m_valid && m_ready) begin
                if (expected_results.size() == 0) begin
                    report_mismatch("unexpected result", m_data.res_num, 64'd0);
                end else begin
                    want = expected_results.pop_front();
                    if (m_data.res_num !== want.res_num)
                        report_mismatch("res_num", m_data.res_num, want.res_num);
                    if (m_data.res_den !== want.res_den)
                        report_mismatch("res_den", 64'(m_data.res_den), 64'(want.res_den));
                    if (m_data.cmp_result !== want.cmp_result)
                        report_mismatch("cmp_result", 64'(m_data.cmp_result),
                                        64'(want.cmp_result));
                    if (m_data.status !== want.status)
                        report_mismatch("status", 64'(m_data.status), 64'(want.status));
                end
            end
            m_ready <= ($urandom_range(0, 99) >= receiver_stall_pct);
        end
    end

    initial begin
        rau_res_t no_res;
        int       wait_cycles;
        error_count        = 0;
        accept_count       = 0;
        sender_idle_pct    = 0;
        receiver_stall_pct = 0;
        aresetn = 1'b0;
        s_valid = 1'b0;
        s_data  = '0;
        no_res  = '0;

        // Directed table; known results only where obvious.
        add_row(make_req(OP_NORM, 0, 5, 0, 0), 1'b1, make_res(0, 1, CMP_LESS, ST_OK));
        add_row(make_req(OP_NORM, -3, -6, 0, 0), 1'b1, make_res(1, 2, CMP_LESS, ST_OK));
        add_row(make_req(OP_NORM, 4, 0, 1, 1), 1'b1, make_res(0, 1, CMP_LESS, ST_ZERO_DEN));
        add_row(make_req(OP_ADD, 1, 2, 1, 0), 1'b1, make_res(0, 1, CMP_LESS, ST_ZERO_DEN));
        add_row(make_req(OP_DIV, 1, 2, 0, 3), 1'b1, make_res(0, 1, CMP_LESS, ST_DIV_ZERO));
        add_row(make_req(OP_DIV, 1, 0, 0, 3), 1'b1, make_res(0, 1, CMP_LESS, ST_ZERO_DEN));
        add_row(make_req(OP_CMP, 1, 2, 2, 4), 1'b1, make_res(0, 1, CMP_EQUAL, ST_OK));
        add_row(make_req(OP_CMP, -1, 2, 1, 3), 1'b1, make_res(0, 1, CMP_LESS, ST_OK));
        add_row(make_req(OP_CMP, 1, -2, -1, 3), 1'b1, make_res(0, 1, CMP_LESS, ST_OK));
        add_row(make_req(rau_op_t'(3'd6), 7, 0, 1, 0), 1'b1,
                make_res(0, 1, CMP_LESS, ST_OK));
        add_row(make_req(rau_op_t'(3'd7), -1, -1, -1, -1), 1'b1,
                make_res(0, 1, CMP_LESS, ST_OK));
        add_row(make_req(OP_ADD, 1, 2, 1, 3), 1'b1, make_res(5, 6, CMP_LESS, ST_OK));
        add_row(make_req(OP_SUB, 1, 2, 1, 2), 1'b1, make_res(0, 1, CMP_LESS, ST_OK));
        add_row(make_req(OP_MUL, 2, 3, 3, 4), 1'b1, make_res(1, 2, CMP_LESS, ST_OK));
        add_row(make_req(OP_DIV, 2, 3, -4, 9), 1'b1, make_res(-3, 2, CMP_LESS, ST_OK));
        add_row(make_req(OP_NORM, 32'h8000_0000, 32'h8000_0000, 0, 0), 1'b0, no_res);
        add_row(make_req(OP_NORM, 32'h8000_0000, -1, 0, 0), 1'b0, no_res);
        add_row(make_req(OP_MUL, 32'h8000_0000, 1, 32'h8000_0000, 1), 1'b0, no_res);
        add_row(make_req(OP_MUL, 32'h8000_0000, 1, 32'h7FFF_FFFF, 1), 1'b0, no_res);
        add_row(make_req(OP_ADD, 32'h8000_0000, 32'h7FFF_FFFF, 32'h8000_0000, 32'h7FFF_FFFF),
                1'b0, no_res);
        add_row(make_req(OP_SUB, 32'h7FFF_FFFF, 32'h8000_0000, 32'h8000_0000, 3), 1'b0, no_res);
        add_row(make_req(OP_DIV, 32'h8000_0000, 32'h7FFF_FFFF, 1, 32'h8000_0000), 1'b0, no_res);
        add_row(make_req(OP_DIV, 32'h7FFF_FFFF, 1, -1, 32'h7FFF_FFFF), 1'b0, no_res);
        add_row(make_req(OP_CMP, 32'h8000_0000, 1, 32'h7FFF_FFFF, 32'h8000_0000), 1'b0, no_res);

        repeat (10) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // Directed rows; the acceptance monitor picks the typed or predicted result.
        for (int k = 0; k < directed_rows.size(); k++) begin
            send_request(directed_rows[k].req);
        end

        // Random phases with different idle and stall mixes.
        for (int phase = 0; phase < 4; phase++) begin
            case (phase)
                0: begin sender_idle_pct = 0;  receiver_stall_pct = 0;  end
                1: begin sender_idle_pct = 64; receiver_stall_pct = 0;  end
                2: begin sender_idle_pct = 0;  receiver_stall_pct = 64; end
                default: begin sender_idle_pct = 32; receiver_stall_pct = 32; end
            endcase
            for (int i = 0; i < 150; i++) begin
                send_request(random_req());
                // Hold off now and then until the unit is fully drained.
                if (i == 75) begin
                    s_valid <= 1'b0;
                    @(posedge aclk);
                    while (expected_results.size() != 0) @(posedge aclk);
                end
            end
        end
        s_valid <= 1'b0;

        wait_cycles = 0;
        while (expected_results.size() != 0 && wait_cycles < 100000) begin
            @(posedge aclk);
            wait_cycles++;
        end
        repeat (300) @(posedge aclk);
        if (error_count == 0 && expected_results.size() == 0) begin
            $display("rational_arithmetic_unit verification clean");
        end else begin
            $display("rational_arithmetic_unit verification failed");
        end
        $finish;
    end

endmodule

// ===== files.f =====
+incdir+src
src/rau_pkg.sv
src/rau_mul.sv
src/rau_gcd.sv
src/rau_div.sv
src/rational_arithmetic_unit.sv
sim/rational_arithmetic_unit_tb.sv
